>>> hdl/itp_pkg.sv
// Shared types, constants and helper functions for the infix-to-postfix converter.
// No dependencies; used by every module of the block.
`default_nettype none

package itp_pkg;

	localparam int STACK_DEPTH   = 32;
	localparam int NUM_OPERATORS = 16;
	localparam int AW            = $clog2(STACK_DEPTH);
	localparam int CW            = $clog2(STACK_DEPTH + 1);

	localparam int IN_DATA_W  = 72;
	localparam int OUT_DATA_W = 72;

	localparam logic [2:0] TK_INT   = 3'd0;
	localparam logic [2:0] TK_FLOAT = 3'd1;
	localparam logic [2:0] TK_OP    = 3'd2;
	localparam logic [2:0] TK_LPAR  = 3'd3;
	localparam logic [2:0] TK_RPAR  = 3'd4;
	localparam logic [2:0] TK_END   = 3'd5;

	localparam logic [1:0] OK_OP   = 2'd2;
	localparam logic [1:0] OK_LPAR = 2'd3;

	typedef struct packed {
		logic latch;
		logic push;
		logic push_paren;
		logic pop;
		logic emit;
		logic emit_tok;
		logic last;
	} itp_cmd_t;

	typedef struct packed {
		logic [2:0] kind;
		logic       op_ok;
		logic       empty;
		logic       top_paren;
		logic       top_pops;
		logic       two_plus;
		logic       below_paren;
		logic       below_pops;
		logic       out_free;
	} itp_stat_t;

	function automatic logic [3:0] prec_of(input logic [63:0] tbl, input logic [3:0] code);
		return tbl[{code, 2'b00} +: 4];
	endfunction

	function automatic logic entry_pops(input logic [63:0] tbl, input logic [15:0] rmask,
		input logic [3:0] new_code, input logic [4:0] entry);
		logic [3:0] sp;
		logic [3:0] p;
		sp = prec_of(tbl, entry[3:0]);
		p  = prec_of(tbl, new_code);
		return rmask[new_code] ? (sp > p) : (sp >= p);
	endfunction

endpackage

`default_nettype wire

>>> hdl/itp_ctrl.sv
// Controller state machine of the infix-to-postfix converter.
// Depends on itp_pkg; drives commands to itp_dpath from its status.
`default_nettype none

module itp_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             s_axis_tvalid,
	output logic                  s_axis_tready,
	input  wire itp_pkg::itp_stat_t stat,
	output itp_pkg::itp_cmd_t     cmd
);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_EVAL = 2'b10
	} itp_state_t;

	itp_state_t state_q;
	itp_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign s_axis_tready = (state_q == ST_IDLE);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (s_axis_tvalid) begin
					cmd.latch = 1'b1;
					state_d   = ST_EVAL;
				end
			end
			ST_EVAL: begin
				unique case (stat.kind)
					itp_pkg::TK_INT, itp_pkg::TK_FLOAT: begin
						if (stat.out_free) begin
							cmd.emit     = 1'b1;
							cmd.emit_tok = 1'b1;
							cmd.last     = 1'b1;
							state_d      = ST_IDLE;
						end
					end
					itp_pkg::TK_OP: begin
						if (!stat.op_ok) begin
							state_d = ST_IDLE;
						end else if (!stat.empty && !stat.top_paren && stat.top_pops) begin
							if (stat.out_free) begin
								cmd.emit = 1'b1;
								cmd.pop  = 1'b1;
								cmd.last = !(stat.two_plus && !stat.below_paren
									&& stat.below_pops);
							end
						end else begin
							cmd.push = 1'b1;
							state_d  = ST_IDLE;
						end
					end
					itp_pkg::TK_LPAR: begin
						cmd.push       = 1'b1;
						cmd.push_paren = 1'b1;
						state_d        = ST_IDLE;
					end
					itp_pkg::TK_RPAR: begin
						if (stat.empty) begin
							state_d = ST_IDLE;
						end else if (stat.top_paren) begin
							cmd.pop = 1'b1;
							state_d = ST_IDLE;
						end else if (stat.out_free) begin
							cmd.emit = 1'b1;
							cmd.pop  = 1'b1;
							cmd.last = !stat.two_plus || stat.below_paren;
						end
					end
					itp_pkg::TK_END: begin
						if (stat.empty) begin
							state_d = ST_IDLE;
						end else if (stat.out_free) begin
							cmd.emit = 1'b1;
							cmd.pop  = 1'b1;
							cmd.last = !stat.two_plus;
						end
					end
					default: begin
						state_d = ST_IDLE;
					end
				endcase
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

>>> hdl/itp_dpath.sv
// Datapath of the infix-to-postfix converter: token register, operator stack
// memory with top and next-below registers, configuration and output register.
// Depends on itp_pkg; controlled by itp_ctrl.
`default_nettype none

module itp_dpath (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic                          cfg_index,
	input  wire logic [63:0]                   cfg_wdata,
	input  wire logic [itp_pkg::IN_DATA_W-1:0] s_axis_tdata,
	input  wire logic [2:0]                    s_axis_tuser,
	output logic                               m_axis_tvalid,
	input  wire logic                          m_axis_tready,
	output logic [itp_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
	output logic [1:0]                         m_axis_tuser,
	output logic                               m_axis_tlast,
	input  wire itp_pkg::itp_cmd_t             cmd,
	output itp_pkg::itp_stat_t                 stat
);

	logic [63:0] prec_q;
	logic [15:0] rmask_q;

	logic [2:0]  tok_kind_q;
	logic [3:0]  tok_code_q;
	logic [63:0] tok_value_q;

	logic [4:0]  stack_mem [itp_pkg::STACK_DEPTH];
	logic [4:0]  top_q;
	logic [4:0]  below_q;
	logic [itp_pkg::CW-1:0] count_q;
	logic [itp_pkg::CW-1:0] count_d;
	logic [itp_pkg::CW-1:0] rd_cnt;
	logic [itp_pkg::AW-1:0] rd_addr;
	logic [itp_pkg::AW-1:0] wr_addr;
	logic        full;
	logic        wr_en;
	logic [4:0]  push_entry;
	logic        ovf_q;

	logic        m_valid_q;
	logic [1:0]  m_kind_q;
	logic [3:0]  m_op_q;
	logic [63:0] m_value_q;
	logic        m_last_q;
	logic        m_ovf_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prec_q  <= '0;
			rmask_q <= '0;
		end else if (cfg_we) begin
			if (cfg_index) begin
				rmask_q <= cfg_wdata[15:0];
			end else begin
				prec_q <= cfg_wdata;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			tok_kind_q  <= s_axis_tuser;
			tok_code_q  <= s_axis_tdata[3:0];
			tok_value_q <= s_axis_tdata[67:4];
		end
	end

	assign full       = (count_q == itp_pkg::CW'(itp_pkg::STACK_DEPTH));
	assign wr_en      = cmd.push && !full;
	assign wr_addr    = count_q[itp_pkg::AW-1:0];
	assign push_entry = cmd.push_paren ? 5'b10000 : {1'b0, tok_code_q};

	always_comb begin
		count_d = count_q;
		if (wr_en) begin
			count_d = count_q + itp_pkg::CW'(1);
		end else if (cmd.pop) begin
			count_d = count_q - itp_pkg::CW'(1);
		end
	end

	assign rd_cnt  = count_d - itp_pkg::CW'(2);
	assign rd_addr = rd_cnt[itp_pkg::AW-1:0];

	// below_q tracks the entry under the top for the count of the next cycle
	always_ff @(posedge clk) begin
		if (wr_en) begin
			stack_mem[wr_addr] <= push_entry;
		end
		below_q <= stack_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			top_q <= push_entry;
		end else if (cmd.pop) begin
			top_q <= below_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			ovf_q   <= 1'b0;
		end else begin
			count_q <= count_d;
			if (cmd.push && full) begin
				ovf_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			m_last_q <= cmd.last;
			m_ovf_q  <= ovf_q;
			if (cmd.emit_tok) begin
				m_kind_q  <= tok_kind_q[1:0];
				m_op_q    <= '0;
				m_value_q <= tok_value_q;
			end else begin
				m_kind_q  <= top_q[4] ? itp_pkg::OK_LPAR : itp_pkg::OK_OP;
				m_op_q    <= top_q[4] ? 4'd0 : top_q[3:0];
				m_value_q <= '0;
			end
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {3'b000, m_ovf_q, m_value_q, m_op_q};
	assign m_axis_tuser  = m_kind_q;
	assign m_axis_tlast  = m_last_q;

	always_comb begin
		stat.kind        = tok_kind_q;
		stat.op_ok       = (32'(tok_code_q) < itp_pkg::NUM_OPERATORS);
		stat.empty       = (count_q == '0);
		stat.top_paren   = top_q[4];
		stat.top_pops    = itp_pkg::entry_pops(prec_q, rmask_q, tok_code_q, top_q);
		stat.two_plus    = (count_q >= itp_pkg::CW'(2));
		stat.below_paren = below_q[4];
		stat.below_pops  = itp_pkg::entry_pops(prec_q, rmask_q, tok_code_q, below_q);
		stat.out_free    = !m_valid_q || m_axis_tready;
	end

endmodule

`default_nettype wire

>>> hdl/infix_to_postfix_converter.sv
// Infix-to-postfix converter: top level joining itp_ctrl and itp_dpath.
// Depends on itp_pkg, itp_ctrl and itp_dpath.
// Number path: a number token is latched into the token register on transfer, evaluated in
// ST_EVAL and then registered into the output register, waiting while that register is stalled.
// Token flow: a new token is taken only in ST_IDLE; in ST_EVAL the controller evaluates one stack
// entry per cycle against the top register while the output register is free; a stall holds it.
// Reset: arst_n clears the controller, stack count, overflow flag, configuration and
// output valid; stack memory contents stay undefined and need no clearing pass.
`default_nettype none

module infix_to_postfix_converter (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic                          cfg_index,
	input  wire logic [63:0]                   cfg_wdata,
	input  wire logic                          s_axis_tvalid,
	output logic                               s_axis_tready,
	input  wire logic [itp_pkg::IN_DATA_W-1:0] s_axis_tdata,  // operator_code, number_value
	input  wire logic [2:0]                    s_axis_tuser,  // token_kind
	output logic                               m_axis_tvalid,
	input  wire logic                          m_axis_tready,
	output logic [itp_pkg::OUT_DATA_W-1:0]     m_axis_tdata,  // out_operator, out_value, overflowed
	output logic [1:0]                         m_axis_tuser,  // out_kind
	output logic                               m_axis_tlast
);

	itp_pkg::itp_cmd_t  cmd;
	itp_pkg::itp_stat_t stat;

	itp_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.stat          (stat),
		.cmd           (cmd)
	);

	itp_dpath u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast),
		.cmd           (cmd),
		.stat          (stat)
	);

endmodule

`default_nettype wire

>>> hdl/itp_checker.sv
// Port-level checker for the infix-to-postfix converter and its bind.
// Depends on itp_pkg; sees only the top-level ports.
`default_nettype none

module itp_props (
	input wire logic                           clk,
	input wire logic                           arst_n,
	input wire logic                           s_axis_tvalid,
	input wire logic                           s_axis_tready,
	input wire logic                           m_axis_tvalid,
	input wire logic                           m_axis_tready,
	input wire logic [itp_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	input wire logic [1:0]                     m_axis_tuser,
	input wire logic                           m_axis_tlast
);

	logic seen_ovf_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_ovf_q <= 1'b0;
		end else if (m_axis_tvalid && m_axis_tready && m_axis_tdata[68]) begin
			seen_ovf_q <= 1'b1;
		end
	end

	a_ovf_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && seen_ovf_q |-> m_axis_tdata[68])
		else $error("overflow flag dropped after being reported");

	a_paren_empty: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser == itp_pkg::OK_LPAR |-> m_axis_tdata[67:0] == 68'd0)
		else $error("unmatched paren result carries payload");

	a_number_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser[1] |-> m_axis_tlast)
		else $error("number result without tlast");

	a_one_token: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("token taken while previous one evaluates");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
			&& $stable(m_axis_tuser) && $stable(m_axis_tlast))
		else $error("output changed while stalled");

endmodule

bind infix_to_postfix_converter itp_props u_itp_props (.*);

`default_nettype wire
